// ===== src/ddo_pkg.sv =====
// Package with shared types and constants for the differential-drive odometry block.
package ddo_pkg;

    // Gain compensation of the rotator, 0.607252935 scaled by 2^30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    // Heading step scale, turn rate times milliseconds to heading units, Q32.
    localparam logic [22:0] HEAD_K = 23'd5468522;
    localparam logic [11:0] TRACK_RESET = 12'd100;
    localparam int ATAN_DEPTH = 24;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0: r = 32'd536870912;
                5'd1: r = 32'd316933406;
                5'd2: r = 32'd167458907;
                5'd3: r = 32'd85004756;
                5'd4: r = 32'd42667331;
                5'd5: r = 32'd21354465;
                5'd6: r = 32'd10679838;
                5'd7: r = 32'd5340245;
                5'd8: r = 32'd2670163;
                5'd9: r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the item and set up divider and rotator
        logic div_step;  // one divider bit
        logic rot_step;  // one rotator iteration
        logic mul_a;     // first multiply phase
        logic mul_b;     // second multiply phase
        logic commit;    // update state and the output register
    } ddo_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic rot_done;
    } ddo_sts_t;

endpackage

// ===== src/ddo_ctrl.sv =====
// Controller state machine that sequences one odometry update.
module ddo_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  ddo_pkg::ddo_sts_t sts,
    output ddo_pkg::ddo_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WORK = 3'd1;
    localparam logic [2:0] S_MULA = 3'd2;
    localparam logic [2:0] S_MULB = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // The output register may be refilled once its item is taken.
    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                cmd.div_step = !sts.div_done;
                cmd.rot_step = !sts.rot_done;
                if (sts.div_done && sts.rot_done)
                    state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_b = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/ddo_datapath.sv =====
// Datapath: divider, rotator, integrators and pose state.
module ddo_datapath #(
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ddo_pkg::ddo_cmd_t  cmd,
    output ddo_pkg::ddo_sts_t  sts,
    input  logic               cfg_we,
    input  logic [11:0]        cfg_data,
    input  logic signed [15:0] left_wheel_speed,
    input  logic signed [15:0] right_wheel_speed,
    input  logic [9:0]         interval_ms,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [15:0]        heading,
    output logic signed [15:0] vel_x,
    output logic signed [15:0] vel_y,
    output logic signed [31:0] turn_rate
);

    localparam int STEPS = (CORDIC_STEPS < ddo_pkg::ATAN_DEPTH) ?
                           CORDIC_STEPS : ddo_pkg::ATAN_DEPTH;
    localparam int AW = ANGLE_BITS + 2;
    // Rotator word: v (17 bits) times gain over 2^14 stays within 35 bits, growth 2 bits.
    localparam int RW = 38;
    localparam int NUM_W = 29;   // |(R-L)*4096| < 2^29

    // Configuration and state registers.
    logic [11:0]        track_reg;
    logic signed [31:0] xpos_reg, ypos_reg;
    logic [15:0]        yaw_reg;
    logic signed [15:0] lvx_reg, lvy_reg;
    logic signed [31:0] lw_reg;
    logic [9:0]         t_reg;

    // Divider registers (restoring, magnitude).
    logic [NUM_W-1:0]   quo_reg;
    logic [12:0]        rem_reg;
    logic [4:0]         dcnt_reg;
    logic               wneg_reg;

    // Rotator registers.
    logic signed [RW-1:0] cx_reg, cy_reg;
    logic signed [AW-1:0] ca_reg;
    logic [4:0]           ccnt_reg;

    // Products after the multiply phases.
    logic signed [31:0] w_reg;
    logic signed [15:0] vx_reg, vy_reg;
    logic signed [27:0] dx_reg, dy_reg;
    logic signed [43:0] p_reg;
    logic [15:0]        dh;

    // Item set-up: speed sum, difference, folded angle and start vector.
    logic signed [16:0] v_sum;
    logic signed [16:0] v_fwd;
    logic signed [16:0] diff;
    logic [NUM_W-1:0]   num_mag;
    logic signed [AW-1:0] a0, a_fold;
    logic signed [47:0] gx;
    logic signed [RW-1:0] x0;
    logic               flip;

    always_comb
    begin
        v_sum = 17'(left_wheel_speed) + 17'(right_wheel_speed);
        v_fwd = v_sum >>> 1;
        diff = 17'(right_wheel_speed) - 17'(left_wheel_speed);
        num_mag = diff[16] ? NUM_W'(-(29'(diff)) <<< 12) : NUM_W'(29'(diff) <<< 12);
        if (ANGLE_BITS >= 16)
            a0 = AW'({2'b00, yaw_reg}) <<< (ANGLE_BITS - 16);
        else
            a0 = AW'(yaw_reg >> (16 - ANGLE_BITS));
        if (a0 >= (AW'(1) <<< (ANGLE_BITS - 1)))
            a0 = a0 - (AW'(1) <<< ANGLE_BITS);
        a_fold = a0;
        flip = 1'b0;
        if (a0 > (AW'(1) <<< (ANGLE_BITS - 2)))
        begin
            a_fold = a0 - (AW'(1) <<< (ANGLE_BITS - 1));
            flip = 1'b1;
        end
        else if (a0 < -(AW'(1) <<< (ANGLE_BITS - 2)))
        begin
            a_fold = a0 + (AW'(1) <<< (ANGLE_BITS - 1));
            flip = 1'b1;
        end
        gx = 48'(v_fwd) * $signed({18'd0, ddo_pkg::GAIN_Q30});
        x0 = RW'(gx >>> 14);
        if (flip)
            x0 = -x0;
    end

    // Divider step: one quotient bit per cycle.
    logic [13:0] rem_sh;
    logic [12:0] trk;
    logic [13:0] rem_sub;
    always_comb
    begin
        trk = (track_reg == 12'd0) ? 13'd1 : {1'b0, track_reg};
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, trk};
    end

    // Rotator step with the rounded arctangent.
    logic [4:0] ci;
    logic [31:0] at32;
    logic [32:0] at_rnd;
    logic signed [AW-1:0] step_a;
    logic signed [RW-1:0] xs, ys;
    always_comb
    begin
        ci = ccnt_reg;
        at32 = ddo_pkg::atan_turn32(ci);
        at_rnd = (33'(at32) + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        step_a = AW'(at_rnd);
        xs = cx_reg >>> ci;
        ys = cy_reg >>> ci;
    end

    // Velocity rounding and saturation.
    function automatic logic signed [15:0] rnd_sat(input logic signed [RW-1:0] q);
        logic signed [RW-1:0] s;
        begin
            s = (q + RW'(32768)) >>> 16;
            if (s > RW'(32767))
                return 16'sh7fff;
            else if (s < -RW'(32768))
                return 16'sh8000;
            else
                return s[15:0];
        end
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [27:0] b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            if (s > 33'sh07fffffff)
                return 32'sh7fffffff;
            else if (s < -33'sh080000000)
                return 32'sh80000000;
            else
                return s[31:0];
        end
    endfunction

    logic signed [16:0] sx, sy;
    logic signed [32:0] sw;
    logic signed [27:0] mx, my;
    logic signed [43:0] pw;
    logic signed [67:0] hp;
    logic signed [31:0] w_val;
    always_comb
    begin
        w_val = wneg_reg ? -32'(quo_reg) : 32'(quo_reg);
        sx = 17'(lvx_reg) + 17'(vx_reg);
        sy = 17'(lvy_reg) + 17'(vy_reg);
        sw = 33'(lw_reg) + 33'(w_reg);
        mx = (28'(sx) * $signed({18'd0, t_reg}) + 28'sd1) >>> 1;
        my = (28'(sy) * $signed({18'd0, t_reg}) + 28'sd1) >>> 1;
        pw = 44'(sw) * $signed({34'd0, t_reg});
        // Heading step from the turn product held since the second multiply phase.
        hp = (68'(p_reg) * $signed({45'd0, ddo_pkg::HEAD_K}) + (68'sd1 <<< 31)) >>> 32;
        dh = hp[15:0];
    end

    assign sts.div_done = (dcnt_reg == 5'(NUM_W));
    assign sts.rot_done = (ccnt_reg == 5'(STEPS));

    // Configuration and pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg <= ddo_pkg::TRACK_RESET;
            xpos_reg <= '0;
            ypos_reg <= '0;
            yaw_reg <= '0;
            lvx_reg <= '0;
            lvy_reg <= '0;
            lw_reg <= '0;
            dcnt_reg <= '0;
            ccnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                track_reg <= cfg_data;
            if (cmd.load)
            begin
                dcnt_reg <= '0;
                ccnt_reg <= '0;
            end
            if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 5'd1;
            if (cmd.rot_step)
                ccnt_reg <= ccnt_reg + 5'd1;
            if (cmd.commit)
            begin
                xpos_reg <= add_sat(xpos_reg, dx_reg);
                ypos_reg <= add_sat(ypos_reg, dy_reg);
                yaw_reg <= yaw_reg + dh;
                lvx_reg <= vx_reg;
                lvy_reg <= vy_reg;
                lw_reg <= w_reg;
            end
        end
    end

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg <= num_mag;
            rem_reg <= '0;
            wneg_reg <= diff[16];
            t_reg <= interval_ms;
            cx_reg <= x0;
            cy_reg <= '0;
            ca_reg <= a_fold;
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[13])
            begin
                rem_reg <= rem_sub[12:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[12:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.rot_step)
        begin
            if (!ca_reg[AW-1])
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                ca_reg <= ca_reg - step_a;
            end
            else
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                ca_reg <= ca_reg + step_a;
            end
        end
        if (cmd.mul_a)
        begin
            vx_reg <= rnd_sat(cx_reg);
            vy_reg <= rnd_sat(cy_reg);
            w_reg <= w_val;
        end
        if (cmd.mul_b)
        begin
            dx_reg <= mx;
            dy_reg <= my;
            p_reg <= pw;
        end
        if (cmd.commit)
        begin
            pos_x <= add_sat(xpos_reg, dx_reg);
            pos_y <= add_sat(ypos_reg, dy_reg);
            heading <= yaw_reg + dh;
            vel_x <= vx_reg;
            vel_y <= vy_reg;
            turn_rate <= w_reg;
        end
    end

endmodule

// ===== src/diff_drive_odometry_top.sv =====
// Top level of the differential-drive odometry block.
// One item passes from acceptance through the bit-serial turn-rate divider, run beside
// the rotator of CORDIC_STEPS iterations, then through two multiply phases and the
// commit; the commit waits while the previous result is still unread.
// A new item is taken once the previous result sits in the output register.
module diff_drive_odometry_top #(
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [11:0]  cfg_data,        // wheel_track_mm
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,    // left_wheel_speed, right_wheel_speed, interval_ms
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata     // pos_x, pos_y, heading, vel_x, vel_y, turn_rate
);

    ddo_pkg::ddo_cmd_t cmd;
    ddo_pkg::ddo_sts_t sts;
    logic signed [31:0] pos_x, pos_y, turn_rate;
    logic [15:0]        heading;
    logic signed [15:0] vel_x, vel_y;

    ddo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ddo_datapath #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .left_wheel_speed  (s_axis_tdata[15:0]),
        .right_wheel_speed (s_axis_tdata[31:16]),
        .interval_ms       (s_axis_tdata[41:32]),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .heading           (heading),
        .vel_x             (vel_x),
        .vel_y             (vel_y),
        .turn_rate         (turn_rate)
    );

    assign m_axis_tdata = {turn_rate, vel_y, vel_x, heading, pos_y, pos_x};

    // Only one item is in flight: no acceptance while a commit is issued.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !s_axis_tready)
        else $error("commit while accepting");

    // A commit always raises the output valid.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("commit without result");

endmodule

// ===== dv/tb_diff_drive_odometry_top.sv =====
// Self-checking testbench for the differential-drive odometry block.
module tb_diff_drive_odometry_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_BITS = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [9:0]         interval_ms;
    } tick_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [31:0] turn_rate;
    } pose_t;

    // One row of the directed table; a negative track means no register write.
    typedef struct {
        int    track;
        tick_t tick;
        bit    typed;
        pose_t pose;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [11:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;

    // Predictor state.
    int          mdl_x;
    int          mdl_y;
    logic [15:0] mdl_yaw;
    int          mdl_vx;
    int          mdl_vy;
    int          mdl_w;
    logic [11:0] mdl_track;

    pose_t pose_fifo[$];
    int    fail_count;
    int    send_idle_pct;
    int    recv_stall_pct;

    diff_drive_odometry_top #(
        .ANGLE_BITS(ANGLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic longint sat_to(input longint v, input longint lo, input longint hi);
        begin
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        end
    endfunction

    // Rotate the forward speed by the heading and return world velocity.
    function automatic void rotate_speed(input logic [15:0] h, input longint v,
                                         output int vx, output int vy);
        longint full;
        longint half;
        longint quarter;
        longint a;
        longint x;
        longint y;
        longint nx;
        longint step;
        begin
            full = longint'(1) << ANGLE_BITS;
            half = full >> 1;
            quarter = full >> 2;
            if (ANGLE_BITS >= 16)
                a = longint'(h) << (ANGLE_BITS - 16);
            else
                a = longint'(h >> (16 - ANGLE_BITS));
            if (a >= half)
                a -= full;
            x = (v * longint'(ddo_pkg::GAIN_Q30)) >>> 14;
            y = 0;
            if (a > quarter)
            begin
                a -= half;
                x = -x;
            end
            else if (a < -quarter)
            begin
                a += half;
                x = -x;
            end
            for (int i = 0; i < CORDIC_STEPS && i < ddo_pkg::ATAN_DEPTH; i++)
            begin
                step = (longint'(ddo_pkg::atan_turn32(5'(i))) +
                        (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
                if (a >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    a -= step;
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    a += step;
                end
                x = nx;
            end
            vx = int'(sat_to((x + 32768) >>> 16, -32768, 32767));
            vy = int'(sat_to((y + 32768) >>> 16, -32768, 32767));
        end
    endfunction

    // Advance the odometry state by one tick and return the new pose.
    function automatic pose_t integrate_tick(input tick_t tk);
        longint l;
        longint r;
        longint t;
        longint trk;
        longint v;
        longint d;
        int     w;
        int     vx;
        int     vy;
        pose_t  p;
        begin
            l = tk.left_speed;
            r = tk.right_speed;
            t = tk.interval_ms;
            trk = (mdl_track == 0) ? 1 : longint'(mdl_track);
            v = (l + r) >>> 1;
            w = int'(sat_to(((r - l) * 4096) / trk, I32_MIN, I32_MAX));
            rotate_speed(mdl_yaw, v, vx, vy);
            d = ((longint'(mdl_vx) + vx) * t + 1) >>> 1;
            mdl_x = int'(sat_to(longint'(mdl_x) + d, I32_MIN, I32_MAX));
            d = ((longint'(mdl_vy) + vy) * t + 1) >>> 1;
            mdl_y = int'(sat_to(longint'(mdl_y) + d, I32_MIN, I32_MAX));
            d = ((longint'(mdl_w) + w) * t * longint'(ddo_pkg::HEAD_K) +
                 (longint'(1) << 31)) >>> 32;
            mdl_yaw = mdl_yaw + d[15:0];
            mdl_vx = vx;
            mdl_vy = vy;
            mdl_w = w;
            p.pos_x = mdl_x;
            p.pos_y = mdl_y;
            p.heading = mdl_yaw;
            p.vel_x = vx[15:0];
            p.vel_y = vy[15:0];
            p.turn_rate = w;
            return p;
        end
    endfunction

    // Hand one tick to the block, idling before it as the phase asks.
    task automatic send_tick(input tick_t tk, input bit typed, input pose_t typed_pose);
        pose_t p;
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {6'd0, tk.interval_ms, tk.right_speed, tk.left_speed};
            #1;
            while (!s_axis_tready)
                @(negedge clk);
            @(posedge clk);
            p = integrate_tick(tk);
            pose_fifo.push_back(typed ? typed_pose : p);
            @(negedge clk);
        end
    endtask

    // Stop sending, wait for every pending pose, then let the block settle.
    task automatic drain_poses();
        begin
            s_axis_tvalid <= 1'b0;
            while (pose_fifo.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_track(input logic [11:0] trk);
        begin
            cfg_we <= 1'b1;
            cfg_data <= trk;
            @(negedge clk);
            cfg_we <= 1'b0;
            mdl_track = trk;
        end
    endtask

    // Random tick: mostly plausible driving, sometimes full-range values.
    function automatic tick_t random_tick();
        tick_t tk;
        int    base;
        begin
            if ($urandom_range(9) < 7)
            begin
                base = $urandom_range(4000) - 2000;
                tk.left_speed = 16'(base + $urandom_range(600) - 300);
                tk.right_speed = 16'(base + $urandom_range(600) - 300);
                tk.interval_ms = 10'($urandom_range(100));
            end
            else
            begin
                tk.left_speed = 16'($urandom);
                tk.right_speed = 16'($urandom);
                tk.interval_ms = 10'($urandom_range(1023));
            end
            return tk;
        end
    endfunction

    // Receiver stall pattern.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        pose_t got;
        pose_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[79:64],
                   m_axis_tdata[95:80], m_axis_tdata[111:96], m_axis_tdata[143:112]};
            if (pose_fifo.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pose_fifo.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x);
                    fail_count++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y);
                    fail_count++;
                end
                if (got.heading !== want.heading)
                begin
                    $error("heading expected %0d got %0d", want.heading, got.heading);
                    fail_count++;
                end
                if (got.vel_x !== want.vel_x)
                begin
                    $error("vel_x expected %0d got %0d", want.vel_x, got.vel_x);
                    fail_count++;
                end
                if (got.vel_y !== want.vel_y)
                begin
                    $error("vel_y expected %0d got %0d", want.vel_y, got.vel_y);
                    fail_count++;
                end
                if (got.turn_rate !== want.turn_rate)
                begin
                    $error("turn_rate expected %0d got %0d", want.turn_rate,
                           got.turn_rate);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    // Main sequence.
    initial
    begin
        row_t  rows[$];
        row_t  rw;
        pose_t zero_pose;
        int    track_plan[6];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mdl_x = 0;
        mdl_y = 0;
        mdl_yaw = '0;
        mdl_vx = 0;
        mdl_vy = 0;
        mdl_w = 0;
        mdl_track = ddo_pkg::TRACK_RESET;
        zero_pose = '0;

        // Directed table: standstill after reset, straight, spins, extremes.
        rows.push_back('{-1, '{16'sd0, 16'sd0, 10'd0}, 1'b1, zero_pose});
        rows.push_back('{-1, '{16'sd0, 16'sd0, 10'd1000}, 1'b1, zero_pose});
        rows.push_back('{-1, '{16'sd1000, 16'sd1000, 10'd10}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd1000, 16'sd1200, 10'd100}, 1'b0, zero_pose});
        rows.push_back('{-1, '{-16'sd500, 16'sd500, 10'd1000}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd800, -16'sd800, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd32767, 16'sd32767, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{-1, '{-16'sd32768, -16'sd32768, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{1, '{-16'sd32768, 16'sd32767, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd32767, -16'sd32768, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd300, 16'sd900, 10'd500}, 1'b0, zero_pose});
        rows.push_back('{4095, '{-16'sd32768, 16'sd32767, 10'd1023}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd2000, 16'sd2100, 10'd777}, 1'b0, zero_pose});
        rows.push_back('{0, '{16'sd100, 16'sd200, 10'd1001}, 1'b0, zero_pose});
        rows.push_back('{-1, '{-16'sd1, 16'sd0, 10'd1}, 1'b0, zero_pose});
        rows.push_back('{-1, '{16'sd5000, 16'sd5000, 10'd1000}, 1'b0, zero_pose});
        rows.push_back('{100, '{16'sd5000, 16'sd5000, 10'd1000}, 1'b0, zero_pose});
        rows.push_back('{-1, '{-16'sd5000, -16'sd5000, 10'd1000}, 1'b0, zero_pose});

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.track >= 0)
            begin
                drain_poses();
                write_track(12'(rw.track));
            end
            send_tick(rw.tick, rw.typed, rw.pose);
        end

        // Random phases with different tracks and idling patterns.
        track_plan = '{$urandom_range(4095), 1, 4095, 0, $urandom_range(1, 300), 100};
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_poses();
            write_track(12'(track_plan[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int n = 0; n < 100; n++)
            begin
                // Midway through each phase, hold off until the block has delivered everything.
                if (n == 50)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (pose_fifo.size() != 0)
                        @(negedge clk);
                end
                send_tick(random_tick(), 1'b0, zero_pose);
            end
        end

        drain_poses();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
src/ddo_pkg.sv
src/ddo_ctrl.sv
src/ddo_datapath.sv
src/diff_drive_odometry_top.sv
dv/tb_diff_drive_odometry_top.sv
